[rtl/bse_pkg.sv]
package bse_pkg;

  // Command codes carried on in_command
  localparam logic [3:0] CMD_TEST      = 4'd0;
  localparam logic [3:0] CMD_SET_BIT   = 4'd1;
  localparam logic [3:0] CMD_CLR_BIT   = 4'd2;
  localparam logic [3:0] CMD_SET_RANGE = 4'd3;
  localparam logic [3:0] CMD_CLR_ALL   = 4'd4;
  localparam logic [3:0] CMD_OR_WORD   = 4'd5;
  localparam logic [3:0] CMD_ANDN_WORD = 4'd6;
  localparam logic [3:0] CMD_CMP_WORD  = 4'd7;
  localparam logic [3:0] CMD_FIND_NEXT = 4'd8;
  localparam logic [3:0] CMD_READ_WORD = 4'd9;

  // Operations of the shared word unit
  localparam logic [2:0] UOP_PASS      = 3'd0;
  localparam logic [2:0] UOP_SET_MASK  = 3'd1;
  localparam logic [2:0] UOP_CLR_MASK  = 3'd2;
  localparam logic [2:0] UOP_OR_OPND   = 3'd3;
  localparam logic [2:0] UOP_ANDN_OPND = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] lo;   // lowest bit of the mask
    logic [5:0] hi;   // highest bit of the mask
  } unit_ctrl_t;

  typedef struct packed {
    logic [63:0] new_word;
    logic        any_set;    // stored word has a set bit under the mask
    logic [5:0]  first_idx;  // lowest such bit
    logic        equal;
    logic        includes;
  } unit_res_t;

  // Position of the lowest set bit; binary search over halves
  function automatic logic [5:0] low_zero_count(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0]  n;
    x = v;
    n = '0;
    if (x[31:0] == 32'd0) begin
      n[5] = 1'b1;
      x = x >> 32;
    end
    if (x[15:0] == 16'd0) begin
      n[4] = 1'b1;
      x = x >> 16;
    end
    if (x[7:0] == 8'd0) begin
      n[3] = 1'b1;
      x = x >> 8;
    end
    if (x[3:0] == 4'd0) begin
      n[2] = 1'b1;
      x = x >> 4;
    end
    if (x[1:0] == 2'd0) begin
      n[1] = 1'b1;
      x = x >> 2;
    end
    if (x[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

[rtl/bse_mem.sv]
module bse_mem #(
  parameter int WORD_COUNT = 64,
  parameter int ADDR_W     = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [63:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [63:0]       rd_data
);

  logic [63:0] mem [WORD_COUNT];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bse_word_unit.sv]
module bse_word_unit (
  input  bse_pkg::unit_ctrl_t ctrl,
  input  logic [63:0]         rd_word,
  input  logic [63:0]         operand,
  output bse_pkg::unit_res_t  res
);

  logic [63:0] mask;
  logic [63:0] masked;
  logic [63:0] new_word;

  // bits lo..hi inclusive
  assign mask   = ({64{1'b1}} << ctrl.lo) & ({64{1'b1}} >> (6'd63 - ctrl.hi));
  assign masked = rd_word & mask;

  always_comb begin
    case (ctrl.op)
      bse_pkg::UOP_SET_MASK:  new_word = rd_word | mask;
      bse_pkg::UOP_CLR_MASK:  new_word = rd_word & ~mask;
      bse_pkg::UOP_OR_OPND:   new_word = rd_word | operand;
      bse_pkg::UOP_ANDN_OPND: new_word = rd_word & ~operand;
      default:                new_word = rd_word;
    endcase
  end

  assign res.new_word  = new_word;
  assign res.any_set   = (masked != 64'd0);
  assign res.first_idx = bse_pkg::low_zero_count(masked);
  assign res.equal     = (rd_word == operand);
  assign res.includes  = ((~rd_word & operand) == 64'd0);

endmodule

[rtl/bitmap_set_engine_core.sv]
// Bitmap store of WORD_COUNT 64-bit words with bit, range, word, clear-all and find-next commands.
// Input: present a command word on the in_ ports with start high; it is taken on a
//   rising edge where start is high and busy is low. busy stays high until the
//   command is finished.
// Result: exactly one result word per command, shown for one cycle with out_valid
//   high. The receiver cannot stall, so results are never held back.
// Config: cfg_bit_length is written when cfg_valid is high (cfg_ready is always
//   high); write it only while the block is idle.
// Timing: refused commands, empty ranges and unused codes answer from idle without
//   a memory read. Bit and word commands do one registered memory read, then one
//   pass through the shared word unit, with write-back for the commands that change
//   the word. Set range and find next walk the words spanned or scanned, one word per
//   cycle through the one read port and one write port. Clear all zeroes one word per cycle.
// Reset: rst_n (synchronous, active low) returns bit_length to 4096 and starts a
//   clearing pass that zeroes every word of the store; busy is high meanwhile and
//   no result comes out of it.
module bitmap_set_engine_core #(
  parameter int WORD_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [11:0] in_bit_index,
  input  logic [12:0] in_end_index,
  input  logic [5:0]  in_word_index,
  input  logic [63:0] in_operand_word,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_bit_length,
  // result channel
  output logic        out_valid,
  output logic        out_bit_value,
  output logic [63:0] out_word_value,
  output logic        out_words_equal,
  output logic        out_word_includes,
  output logic        out_found,
  output logic [11:0] out_found_index,
  output logic        out_index_error
);

  localparam int AW      = ($clog2(WORD_COUNT) > 0) ? $clog2(WORD_COUNT) : 1;
  localparam int CapBits = WORD_COUNT * 64;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  localparam logic [AW-1:0] LastAddr = AW'(WORD_COUNT - 1);

  // sequencer state
  logic [1:0]    state_r, state_nxt;
  logic [3:0]    cmd_r, cmd_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [5:0]    lo_r, lo_nxt;
  logic [5:0]    hi_r, hi_nxt;
  logic          first_r, first_nxt;
  logic [63:0]   op_r, op_nxt;
  logic          clr_reply_r, clr_reply_nxt;
  logic [12:0]   cfg_r;

  // result registers
  logic        out_valid_r, out_valid_nxt;
  logic        bit_value_r, bit_value_nxt;
  logic [63:0] word_value_r, word_value_nxt;
  logic        words_equal_r, words_equal_nxt;
  logic        word_includes_r, word_includes_nxt;
  logic        found_r, found_nxt;
  logic [11:0] found_index_r, found_index_nxt;
  logic        index_error_r, index_error_nxt;

  // length in use
  logic [12:0] len_w;
  logic [7:0]  used_w;
  logic        bit_err, rng_err, rng_empty, word_err;
  logic [12:0] end_m1;
  logic        is_word_cmd;
  logic        more_words;
  logic        at_last;

  // memory and word unit
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_data;
  bse_pkg::unit_ctrl_t unit_ctrl;
  bse_pkg::unit_res_t  unit_res;

  assign len_w  = ({19'd0, cfg_r} > 32'(CapBits)) ? 13'(CapBits) : cfg_r;
  assign used_w = 8'((14'(len_w) + 14'd63) >> 6);

  assign bit_err     = ({1'b0, in_bit_index} >= len_w);
  assign rng_err     = (in_end_index > len_w);
  assign rng_empty   = ({1'b0, in_bit_index} >= in_end_index);
  assign word_err    = ({2'b00, in_word_index} >= used_w);
  assign end_m1      = in_end_index - 13'd1;
  assign is_word_cmd = (in_command inside {bse_pkg::CMD_OR_WORD, bse_pkg::CMD_ANDN_WORD,
                                           bse_pkg::CMD_CMP_WORD, bse_pkg::CMD_READ_WORD});

  assign at_last    = (cur_r == last_r);
  assign more_words = (({{(32-AW){1'b0}}, cur_r} + 32'd1) < {24'd0, used_w});

  // read address: the first word of a new command, else the next word of a walk
  assign rd_addr = (state_r == S_IDLE)
                   ? (is_word_cmd ? AW'(in_word_index) : AW'(in_bit_index[11:6]))
                   : cur_r + AW'(1);

  // shared unit control: mask edges only bite on the first and last word
  always_comb begin
    unit_ctrl.lo = first_r ? lo_r : 6'd0;
    unit_ctrl.hi = at_last ? hi_r : 6'd63;
    case (cmd_r)
      bse_pkg::CMD_SET_BIT,
      bse_pkg::CMD_SET_RANGE: unit_ctrl.op = bse_pkg::UOP_SET_MASK;
      bse_pkg::CMD_CLR_BIT:   unit_ctrl.op = bse_pkg::UOP_CLR_MASK;
      bse_pkg::CMD_OR_WORD:   unit_ctrl.op = bse_pkg::UOP_OR_OPND;
      bse_pkg::CMD_ANDN_WORD: unit_ctrl.op = bse_pkg::UOP_ANDN_OPND;
      default:                unit_ctrl.op = bse_pkg::UOP_PASS;
    endcase
  end

  bse_word_unit u_unit (
    .ctrl    (unit_ctrl),
    .rd_word (rd_data),
    .operand (op_r),
    .res     (unit_res)
  );

  bse_mem #(
    .WORD_COUNT (WORD_COUNT),
    .ADDR_W     (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign wr_addr = cur_r;

  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    cur_nxt           = cur_r;
    last_nxt          = last_r;
    lo_nxt            = lo_r;
    hi_nxt            = hi_r;
    first_nxt         = first_r;
    op_nxt            = op_r;
    clr_reply_nxt     = clr_reply_r;
    wr_en             = 1'b0;
    wr_data           = unit_res.new_word;
    out_valid_nxt     = 1'b0;
    bit_value_nxt     = 1'b0;
    word_value_nxt    = 64'd0;
    words_equal_nxt   = 1'b0;
    word_includes_nxt = 1'b0;
    found_nxt         = 1'b0;
    found_index_nxt   = 12'd0;
    index_error_nxt   = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // zero one word per cycle
        wr_en   = 1'b1;
        wr_data = 64'd0;
        cur_nxt = cur_r + AW'(1);
        if (cur_r == LastAddr) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = clr_reply_r;
          clr_reply_nxt = 1'b0;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          op_nxt    = in_operand_word;
          first_nxt = 1'b1;
          cur_nxt   = AW'(in_bit_index[11:6]);
          last_nxt  = AW'(in_bit_index[11:6]);
          lo_nxt    = in_bit_index[5:0];
          hi_nxt    = in_bit_index[5:0];
          case (in_command)
            bse_pkg::CMD_TEST,
            bse_pkg::CMD_SET_BIT,
            bse_pkg::CMD_CLR_BIT,
            bse_pkg::CMD_FIND_NEXT: begin
              if (in_command == bse_pkg::CMD_FIND_NEXT) begin
                hi_nxt = 6'd63;
              end
              if (bit_err) begin
                out_valid_nxt   = 1'b1;
                index_error_nxt = 1'b1;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            bse_pkg::CMD_SET_RANGE: begin
              last_nxt = AW'(end_m1[12:6]);
              hi_nxt   = end_m1[5:0];
              if (rng_err) begin
                out_valid_nxt   = 1'b1;
                index_error_nxt = 1'b1;
              end else if (rng_empty) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            bse_pkg::CMD_CLR_ALL: begin
              state_nxt     = S_CLEAR;
              cur_nxt       = '0;
              clr_reply_nxt = 1'b1;
            end
            bse_pkg::CMD_OR_WORD,
            bse_pkg::CMD_ANDN_WORD,
            bse_pkg::CMD_CMP_WORD,
            bse_pkg::CMD_READ_WORD: begin
              cur_nxt  = AW'(in_word_index);
              last_nxt = AW'(in_word_index);
              if (word_err) begin
                out_valid_nxt   = 1'b1;
                index_error_nxt = 1'b1;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            default: begin
              // unused code: answer with all zeros
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_EXEC: begin
        case (cmd_r)
          bse_pkg::CMD_TEST: begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            bit_value_nxt = unit_res.any_set;
          end
          bse_pkg::CMD_SET_BIT,
          bse_pkg::CMD_CLR_BIT: begin
            wr_en         = 1'b1;
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end
          bse_pkg::CMD_SET_RANGE: begin
            wr_en = 1'b1;
            if (at_last) begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
            end else begin
              cur_nxt   = cur_r + AW'(1);
              first_nxt = 1'b0;
            end
          end
          bse_pkg::CMD_FIND_NEXT: begin
            if (unit_res.any_set) begin
              state_nxt       = S_IDLE;
              out_valid_nxt   = 1'b1;
              found_nxt       = 1'b1;
              found_index_nxt = 12'({cur_r, unit_res.first_idx});
            end else if (more_words) begin
              // advance to the next word; its read is already under way
              cur_nxt   = cur_r + AW'(1);
              last_nxt  = cur_r + AW'(1);
              first_nxt = 1'b0;
            end else begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
            end
          end
          bse_pkg::CMD_OR_WORD,
          bse_pkg::CMD_ANDN_WORD,
          bse_pkg::CMD_CMP_WORD,
          bse_pkg::CMD_READ_WORD: begin
            wr_en          = (cmd_r == bse_pkg::CMD_OR_WORD) ||
                             (cmd_r == bse_pkg::CMD_ANDN_WORD);
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            word_value_nxt = unit_res.new_word;
            if (cmd_r == bse_pkg::CMD_CMP_WORD) begin
              words_equal_nxt   = unit_res.equal;
              word_includes_nxt = unit_res.includes;
            end
          end
          default: begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_r       <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= 13'd4096;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cfg_r <= cfg_bit_length;
      end
    end
  end

  // hold the command word and result payload
  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    last_r          <= last_nxt;
    lo_r            <= lo_nxt;
    hi_r            <= hi_nxt;
    first_r         <= first_nxt;
    op_r            <= op_nxt;
    bit_value_r     <= bit_value_nxt;
    word_value_r    <= word_value_nxt;
    words_equal_r   <= words_equal_nxt;
    word_includes_r <= word_includes_nxt;
    found_r         <= found_nxt;
    found_index_r   <= found_index_nxt;
    index_error_r   <= index_error_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_bit_value     = bit_value_r;
  assign out_word_value    = word_value_r;
  assign out_words_equal   = words_equal_r;
  assign out_word_includes = word_includes_r;
  assign out_found         = found_r;
  assign out_found_index   = found_index_r;
  assign out_index_error   = index_error_r;

endmodule

[tb/bitmap_set_engine_core_tb.sv]
`timescale 1ns / 100ps

module bitmap_set_engine_core_tb;

  localparam int WORDS     = 64;
  localparam int BITS      = WORDS * 64;
  // Longest legal quiet stretch is a clear-all or a full scan plus a sender gap;
  // allow many times that.
  localparam int QUIET_MAX = 2000;
  localparam int TAIL_WAIT = 100;

  localparam logic [63:0] ONES = '1;

  typedef enum logic [1:0] {ENT_CMD, ENT_CFG, ENT_DRAIN, ENT_PHASE} entry_kind_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [11:0] bit_index;
    logic [12:0] end_index;
    logic [5:0]  word_index;
    logic [63:0] operand_word;
  } bitmap_cmd_t;

  typedef struct packed {
    logic        bit_value;
    logic [63:0] word_value;
    logic        words_equal;
    logic        word_includes;
    logic        found;
    logic [11:0] found_index;
    logic        index_error;
  } bitmap_res_t;

  // One entry of the stimulus plan: a command word, a length write, a pause
  // until everything has drained, or a change of the sender's idle rate.
  typedef struct {
    entry_kind_t kind;
    bitmap_cmd_t cmd;
    logic [12:0] length;
    int          idle_pct;
  } stim_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_command = '0;
  logic [11:0] in_bit_index = '0;
  logic [12:0] in_end_index = '0;
  logic [5:0]  in_word_index = '0;
  logic [63:0] in_operand_word = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_bit_length = '0;
  logic        out_valid;
  logic        out_bit_value;
  logic [63:0] out_word_value;
  logic        out_words_equal;
  logic        out_word_includes;
  logic        out_found;
  logic [11:0] out_found_index;
  logic        out_index_error;

  stim_entry_t pending_q[$];
  bitmap_res_t expected_q[$];

  // Shadow copy of the store and of the length register
  logic [63:0] shadow_words [WORDS];
  logic [12:0] shadow_length;

  int send_idle_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  bitmap_set_engine_core #(
    .WORD_COUNT(WORDS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_bit_index     (in_bit_index),
    .in_end_index     (in_end_index),
    .in_word_index    (in_word_index),
    .in_operand_word  (in_operand_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bit_length   (cfg_bit_length),
    .out_valid        (out_valid),
    .out_bit_value    (out_bit_value),
    .out_word_value   (out_word_value),
    .out_words_equal  (out_words_equal),
    .out_word_includes(out_word_includes),
    .out_found        (out_found),
    .out_found_index  (out_found_index),
    .out_index_error  (out_index_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow store and return the result word it
  // should produce.
  function automatic bitmap_res_t apply_command(input bitmap_cmd_t c);
    int          len;
    int          used;
    int          w;
    int          ws;
    int          we;
    int          last;
    int          lo;
    int          b;
    logic [63:0] m;
    logic [63:0] cur;
    bitmap_res_t r;
    r = '0;
    // Length saturates at the size of the store
    len = (shadow_length < BITS) ? int'(shadow_length) : BITS;
    used = (len + 63) / 64;
    case (c.command)
      bse_pkg::CMD_TEST,
      bse_pkg::CMD_SET_BIT,
      bse_pkg::CMD_CLR_BIT,
      bse_pkg::CMD_FIND_NEXT: begin
        if (c.bit_index >= len) begin
          r.index_error = 1'b1;
        end else begin
          w = c.bit_index / 64;
          m = 64'd1 << c.bit_index[5:0];
          if (c.command == bse_pkg::CMD_TEST) begin
            r.bit_value = |(shadow_words[w] & m);
          end else if (c.command == bse_pkg::CMD_SET_BIT) begin
            shadow_words[w] |= m;
          end else if (c.command == bse_pkg::CMD_CLR_BIT) begin
            shadow_words[w] &= ~m;
          end else begin
            // Mask off bits below the start, then walk whole words up to the
            // last word in use; stray bits past the length still count.
            cur = shadow_words[w] & (ONES << c.bit_index[5:0]);
            while (cur == '0 && w + 1 < used) begin
              w++;
              cur = shadow_words[w];
            end
            if (cur != '0) begin
              lo = 0;
              for (b = 63; b >= 0; b--) begin
                if (cur[b]) lo = b;
              end
              r.found = 1'b1;
              r.found_index = 12'(w * 64 + lo);
            end
          end
        end
      end
      bse_pkg::CMD_SET_RANGE: begin
        if (c.end_index > len) begin
          r.index_error = 1'b1;
        end else if (c.bit_index < c.end_index) begin
          last = int'(c.end_index) - 1;
          ws = c.bit_index / 64;
          we = last / 64;
          for (w = ws; w <= we; w++) begin
            m = ONES;
            if (w == ws) m &= ONES << c.bit_index[5:0];
            if (w == we) m &= ONES >> (63 - (last % 64));
            shadow_words[w] |= m;
          end
        end
      end
      bse_pkg::CMD_CLR_ALL: begin
        foreach (shadow_words[i]) shadow_words[i] = '0;
      end
      bse_pkg::CMD_OR_WORD,
      bse_pkg::CMD_ANDN_WORD,
      bse_pkg::CMD_CMP_WORD,
      bse_pkg::CMD_READ_WORD: begin
        if (c.word_index >= used) begin
          r.index_error = 1'b1;
        end else begin
          if (c.command == bse_pkg::CMD_OR_WORD) begin
            shadow_words[c.word_index] |= c.operand_word;
          end else if (c.command == bse_pkg::CMD_ANDN_WORD) begin
            shadow_words[c.word_index] &= ~c.operand_word;
          end
          r.word_value = shadow_words[c.word_index];
          if (c.command == bse_pkg::CMD_CMP_WORD) begin
            r.words_equal = (r.word_value == c.operand_word);
            r.word_includes = ((~r.word_value & c.operand_word) == '0);
          end
        end
      end
      default: begin
        // unused codes leave the store alone and answer with all zeros
      end
    endcase
    return r;
  endfunction

  task automatic push_cmd(input logic [3:0] cmd, input int bi, input int ei, input int wi,
                          input logic [63:0] op);
    stim_entry_t e;
    e.kind = ENT_CMD;
    e.cmd.command = cmd;
    e.cmd.bit_index = bi[11:0];
    e.cmd.end_index = ei[12:0];
    e.cmd.word_index = wi[5:0];
    e.cmd.operand_word = op;
    e.length = '0;
    e.idle_pct = 0;
    pending_q.push_back(e);
  endtask

  task automatic push_ctrl(input entry_kind_t kind, input int value);
    stim_entry_t e;
    e.kind = kind;
    e.cmd = '0;
    e.length = value[12:0];
    e.idle_pct = value;
    pending_q.push_back(e);
  endtask

  // Mostly legal positions, with extra weight on both ends of the range
  function automatic int pick_index(input int lim);
    int unsigned draw;
    if (lim <= 0) return $urandom_range(0, BITS - 1);
    draw = $urandom_range(0, 99);
    if (draw < 8) return lim - 1;
    if (draw < 12) return 0;
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ONES;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_random_cmd(input int lenv);
    int unsigned draw;
    int          used;
    int          bi;
    int          ei;
    int          wi;
    int          span;
    logic [3:0]  cmd;
    used = (lenv + 63) / 64;
    bi = pick_index(lenv);
    wi = pick_index(used);
    ei = $urandom_range(0, BITS);
    draw = $urandom_range(0, 99);
    if (draw < 8) begin
      // noise: any code, any position
      cmd = 4'($urandom_range(0, 15));
      bi = $urandom_range(0, BITS - 1);
      wi = $urandom_range(0, WORDS - 1);
    end else begin
      draw = $urandom_range(0, 99);
      if (draw < 12) cmd = bse_pkg::CMD_TEST;
      else if (draw < 24) cmd = bse_pkg::CMD_SET_BIT;
      else if (draw < 32) cmd = bse_pkg::CMD_CLR_BIT;
      else if (draw < 42) cmd = bse_pkg::CMD_SET_RANGE;
      else if (draw < 44) cmd = bse_pkg::CMD_CLR_ALL;
      else if (draw < 54) cmd = bse_pkg::CMD_OR_WORD;
      else if (draw < 62) cmd = bse_pkg::CMD_ANDN_WORD;
      else if (draw < 72) cmd = bse_pkg::CMD_CMP_WORD;
      else if (draw < 86) cmd = bse_pkg::CMD_FIND_NEXT;
      else cmd = bse_pkg::CMD_READ_WORD;
      if (cmd == bse_pkg::CMD_SET_RANGE) begin
        draw = $urandom_range(0, 99);
        if (draw < 10 && lenv < BITS) begin
          ei = $urandom_range(lenv + 1, BITS);
        end else if (draw < 16) begin
          ei = $urandom_range(0, bi);
        end else begin
          // mostly short runs, now and then a long one
          span = (draw < 24) ? BITS : 150;
          ei = bi + 1 + $urandom_range(0, span);
          if (ei > lenv) ei = lenv;
        end
      end
    end
    push_cmd(cmd, bi, ei, wi, pick_operand());
  endtask

  // Driver: present the head of the plan. A command word is held on the in_
  // ports until it is taken; length writes and pauses wait for the block to
  // go quiet with nothing outstanding.
  always @(posedge clk) begin : cmd_driver
    logic next_start;
    logic next_cfg;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      in_command <= '0;
      in_bit_index <= '0;
      in_end_index <= '0;
      in_word_index <= '0;
      in_operand_word <= '0;
      cfg_bit_length <= '0;
      foreach (shadow_words[i]) shadow_words[i] = '0;
      shadow_length = 13'd4096;
    end else begin
      next_start = start;
      next_cfg = cfg_valid;
      // Word taken: predict its result and drop it from the plan
      if (start && !busy) begin
        expected_q.push_back(apply_command(pending_q[0].cmd));
        void'(pending_q.pop_front());
        next_start = 1'b0;
      end
      // Length written: mirror it in the shadow register
      if (cfg_valid && cfg_ready) begin
        shadow_length = pending_q[0].length;
        void'(pending_q.pop_front());
        next_cfg = 1'b0;
      end
      if (!next_start && !next_cfg && pending_q.size() != 0) begin
        case (pending_q[0].kind)
          ENT_PHASE: begin
            send_idle_pct = pending_q[0].idle_pct;
            void'(pending_q.pop_front());
          end
          ENT_DRAIN: begin
            if (expected_q.size() == 0 && !busy) void'(pending_q.pop_front());
          end
          ENT_CFG: begin
            if (expected_q.size() == 0 && !busy) begin
              next_cfg = 1'b1;
              cfg_bit_length <= pending_q[0].length;
            end
          end
          default: begin
            // Idle this cycle at the phase's rate, otherwise raise start
            if ($urandom_range(0, 99) >= send_idle_pct) begin
              next_start = 1'b1;
              in_command <= pending_q[0].cmd.command;
              in_bit_index <= pending_q[0].cmd.bit_index;
              in_end_index <= pending_q[0].cmd.end_index;
              in_word_index <= pending_q[0].cmd.word_index;
              in_operand_word <= pending_q[0].cmd.operand_word;
            end
          end
        endcase
      end
      // One assignment per step, so a start held across items never dips
      start <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: every strobed result word is matched against the oldest prediction
  always @(posedge clk) begin : result_monitor
    bitmap_res_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: stray result word: expected none, actual word %h index %h err %b",
                 $time, out_word_value, out_found_index, out_index_error);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("bit_value", 64'(want.bit_value), 64'(out_bit_value));
        check_field("word_value", want.word_value, out_word_value);
        check_field("words_equal", 64'(want.words_equal), 64'(out_words_equal));
        check_field("word_includes", 64'(want.word_includes), 64'(out_word_includes));
        check_field("found", 64'(want.found), 64'(out_found));
        check_field("found_index", 64'(want.found_index), 64'(out_found_index));
        check_field("index_error", 64'(want.index_error), 64'(out_index_error));
      end
    end
  end

  // Watchdog: any handshake restarts the count
  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int seg_len [8] = '{4096, 64, 0, 65, 1, 4095, -1, 4096};
    int seg_items [8] = '{150, 140, 20, 140, 60, 140, 150, 150};
    int idle_plan [4] = '{0, 67, 0, 37};
    int lenv;
    int s;
    int k;

    // Directed part at the reset length
    push_ctrl(ENT_PHASE, 0);
    push_cmd(bse_pkg::CMD_TEST, 0, 0, 0, '0);
    push_cmd(bse_pkg::CMD_SET_BIT, BITS - 1, 0, 0, ONES);
    push_cmd(bse_pkg::CMD_SET_BIT, 0, 0, 0, '0);
    push_cmd(bse_pkg::CMD_FIND_NEXT, 1, 0, 0, '0);
    push_cmd(bse_pkg::CMD_TEST, BITS - 1, 0, 63, '0);
    push_cmd(bse_pkg::CMD_CLR_BIT, BITS - 1, 0, 0, '0);
    push_cmd(bse_pkg::CMD_FIND_NEXT, 1, 0, 0, '0);
    push_cmd(bse_pkg::CMD_SET_RANGE, 5, 200, 0, '0);
    push_cmd(bse_pkg::CMD_READ_WORD, 0, 0, 3, '0);
    push_cmd(bse_pkg::CMD_SET_RANGE, 0, BITS, 0, '0);
    push_cmd(bse_pkg::CMD_SET_RANGE, 300, 300, 0, '0);
    push_cmd(bse_pkg::CMD_ANDN_WORD, 0, 0, 63, {32{2'b10}});
    push_cmd(bse_pkg::CMD_CMP_WORD, 0, 0, 63, {32{2'b01}});
    push_cmd(bse_pkg::CMD_CMP_WORD, 0, 0, 63, 64'd1);
    push_cmd(bse_pkg::CMD_OR_WORD, 0, 0, 0, ONES);
    push_cmd(bse_pkg::CMD_CLR_ALL, 0, 0, 0, '0);
    push_cmd(4'hF, BITS - 1, BITS, 63, ONES);
    // Partial last word: bits past the length are still reachable word-wise
    push_ctrl(ENT_CFG, 100);
    push_cmd(bse_pkg::CMD_SET_BIT, 100, 0, 0, '0);
    push_cmd(bse_pkg::CMD_OR_WORD, 0, 0, 1, ONES);
    push_cmd(bse_pkg::CMD_FIND_NEXT, 70, 0, 0, '0);
    push_cmd(bse_pkg::CMD_READ_WORD, 0, 0, 2, '0);
    push_cmd(bse_pkg::CMD_SET_RANGE, 0, 101, 0, '0);
    push_cmd(bse_pkg::CMD_CLR_ALL, 0, 0, 0, '0);
    // Zero length: everything positional is refused, an empty range is not
    push_ctrl(ENT_CFG, 0);
    push_cmd(bse_pkg::CMD_TEST, 0, 0, 0, '0);
    push_cmd(bse_pkg::CMD_SET_RANGE, 0, 0, 0, '0);
    push_cmd(bse_pkg::CMD_READ_WORD, 0, 0, 0, '0);

    // Random part: one length per segment, sender idle rate rotating
    for (s = 0; s < 8; s++) begin
      lenv = (seg_len[s] < 0) ? $urandom_range(2, BITS) : seg_len[s];
      push_ctrl(ENT_CFG, lenv);
      push_ctrl(ENT_PHASE, idle_plan[s % 4]);
      for (k = 0; k < seg_items[s]; k++) begin
        if (s == 1 && k == seg_items[s] / 2) push_ctrl(ENT_DRAIN, 0);
        push_random_cmd(lenv);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || expected_q.size() != 0 || start) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
